FILE: hw/rtl/nvic_pkg.sv
// Shared constants, types and helper functions of the interrupt controller register block.
package nvic_pkg;

    // Number of interrupt lines and the storage it implies
    localparam int NUM_IRQ     = 64;
    localparam int BIT_WORDS   = (NUM_IRQ + 31) / 32;
    localparam int PRIO_WORDS  = (NUM_IRQ + 3) / 4;
    localparam int BIT_IDX_W   = (BIT_WORDS > 1) ? $clog2(BIT_WORDS) : 1;
    localparam int PRIO_IDX_W  = (PRIO_WORDS > 1) ? $clog2(PRIO_WORDS) : 1;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 9;
    localparam int DATA_W      = 32;
    localparam int ID_W        = 6;
    localparam int PRIO_W      = 3;
    localparam int LANES       = 4;
    localparam int PRIO_WORD_W = PRIO_W * LANES;
    localparam int PRIO_SHIFT  = 5;

    // Stream packing
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 32;

    // Register map, word addresses
    localparam logic [ADDR_W-1:0] BASE_SET_EN   = 9'h040;
    localparam logic [ADDR_W-1:0] BASE_CLR_EN   = 9'h060;
    localparam logic [ADDR_W-1:0] BASE_SET_PEND = 9'h080;
    localparam logic [ADDR_W-1:0] BASE_CLR_PEND = 9'h0A0;
    localparam logic [ADDR_W-1:0] BASE_ACTIVE   = 9'h0C0;
    localparam logic [ADDR_W-1:0] BASE_PRIO     = 9'h100;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_ACT_SET = 2'd2,
        CMD_ACT_CLR = 2'd3
    } cmd_t;

    // Decoded access, passed from the decoder to the register file
    typedef struct packed {
        logic                  wr;
        logic                  act_set;
        logic                  act_clr;
        logic                  act_ok;
        logic                  hit_set_en;
        logic                  hit_clr_en;
        logic                  hit_set_pend;
        logic                  hit_clr_pend;
        logic                  hit_active;
        logic                  hit_prio;
        logic                  err;
        logic [BIT_IDX_W-1:0]  bit_idx;
        logic [PRIO_IDX_W-1:0] prio_idx;
        logic [BIT_IDX_W-1:0]  act_idx;
        logic [4:0]            act_bit;
    } dec_t;

    // Implemented lines of one 32-bit bit word
    function automatic logic [DATA_W-1:0] line_mask(input logic [BIT_IDX_W-1:0] w);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            m[i] = ((int'(w) * 32 + i) < NUM_IRQ);
        end
        return m;
    endfunction

    // Implemented lanes of one priority word
    function automatic logic [LANES-1:0] lane_mask(input logic [PRIO_IDX_W-1:0] p);
        logic [LANES-1:0] m;
        m = '0;
        for (int k = 0; k < LANES; k++)
        begin
            m[k] = ((int'(p) * LANES + k) < NUM_IRQ);
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/nested_interrupt_controller_regs.sv
// Top level of the interrupt controller register block: input and result registers.
// The input register holds each accepted item until its result is captured.
// Throughput: one item per cycle unless m_axis_tready stalls the output; the input
// and result registers each advance whenever the next stage is empty or being drained.
// Reset: rst_n clears all enable, pending, active and priority bits and empties
// both pipeline registers; the block is ready for items once reset is released.
module nested_interrupt_controller_regs
    import nvic_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // word_address, write_data, irq_id, pad
    input  logic [CMD_W-1:0]     s_axis_tuser,   // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // read_data
    output logic                 m_axis_tuser    // addr_error
);

    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [ID_W-1:0]   id_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              err_reg;
    logic              adv_out;
    logic              adv_in;
    dec_t              dec;
    logic [DATA_W-1:0] rdata_next;

    // Handshake: advance each stage when the one after it can take the item
    assign adv_out       = !out_valid_reg || m_axis_tready;
    assign adv_in        = !in_valid_reg || adv_out;
    assign s_axis_tready = adv_in;

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv_in)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && s_axis_tvalid)
        begin
            cmd_reg   <= s_axis_tuser;
            addr_reg  <= s_axis_tdata[ADDR_W-1:0];
            wdata_reg <= s_axis_tdata[ADDR_W +: DATA_W];
            id_reg    <= s_axis_tdata[ADDR_W + DATA_W +: ID_W];
        end
    end

    nvic_decode u_decode (
        .cmd          (cmd_reg),
        .word_address (addr_reg),
        .irq_id       (id_reg),
        .dec          (dec)
    );

    nvic_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_valid_reg && adv_out),
        .dec        (dec),
        .write_data (wdata_reg),
        .read_data  (rdata_next)
    );

    // Capture the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && in_valid_reg)
        begin
            rdata_reg <= rdata_next;
            err_reg   <= dec.err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rdata_reg;
    assign m_axis_tuser  = err_reg;

endmodule

FILE: hw/rtl/nvic_decode.sv
// Address and command decoder of the interrupt controller register block.
module nvic_decode
    import nvic_pkg::*;
(
    input  logic [CMD_W-1:0]  cmd,
    input  logic [ADDR_W-1:0] word_address,
    input  logic [ID_W-1:0]   irq_id,
    output dec_t              dec
);

    logic             bus;
    logic [3:0]       win;
    logic             off_ok;
    logic             prio_ok;
    logic             any_hit;

    // Split the address into a window code and an offset
    assign win     = word_address[ADDR_W-1:5];
    assign off_ok  = (word_address[4:0] < 5'(BIT_WORDS));
    assign prio_ok = word_address[8] && (word_address[7:0] < 8'(PRIO_WORDS));
    assign bus     = (cmd == CMD_READ) || (cmd == CMD_WRITE);

    // Build the decoded access
    always_comb
    begin
        dec              = '0;
        dec.wr           = (cmd == CMD_WRITE);
        dec.act_set      = (cmd == CMD_ACT_SET);
        dec.act_clr      = (cmd == CMD_ACT_CLR);
        dec.act_ok       = (32'(irq_id) < 32'(NUM_IRQ));
        dec.act_idx      = BIT_IDX_W'(irq_id >> 5);
        dec.act_bit      = irq_id[4:0];
        dec.bit_idx      = word_address[BIT_IDX_W-1:0];
        dec.prio_idx     = word_address[PRIO_IDX_W-1:0];
        dec.hit_set_en   = bus && off_ok && (win == BASE_SET_EN[ADDR_W-1:5]);
        dec.hit_clr_en   = bus && off_ok && (win == BASE_CLR_EN[ADDR_W-1:5]);
        dec.hit_set_pend = bus && off_ok && (win == BASE_SET_PEND[ADDR_W-1:5]);
        dec.hit_clr_pend = bus && off_ok && (win == BASE_CLR_PEND[ADDR_W-1:5]);
        dec.hit_active   = bus && off_ok && (win == BASE_ACTIVE[ADDR_W-1:5]);
        dec.hit_prio     = bus && prio_ok;
        any_hit          = dec.hit_set_en || dec.hit_clr_en || dec.hit_set_pend
                        || dec.hit_clr_pend || dec.hit_active || dec.hit_prio;
        dec.err          = bus && !any_hit;
    end

endmodule

FILE: hw/rtl/nvic_regfile.sv
// Enable, pending, active and priority registers with their read mux.
module nvic_regfile
    import nvic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dec_t              dec,
    input  logic [DATA_W-1:0] write_data,
    output logic [DATA_W-1:0] read_data
);

    logic [DATA_W-1:0]      enable_reg  [BIT_WORDS];
    logic [DATA_W-1:0]      pending_reg [BIT_WORDS];
    logic [DATA_W-1:0]      active_reg  [BIT_WORDS];
    logic [PRIO_WORD_W-1:0] prio_reg    [PRIO_WORDS];
    logic [DATA_W-1:0]      wmask;
    logic [LANES-1:0]       lmask;
    logic [PRIO_WORD_W-1:0] prio_wr;

    assign wmask = line_mask(dec.bit_idx);
    assign lmask = lane_mask(dec.prio_idx);

    // Merge written lanes into the stored priority word
    always_comb
    begin
        prio_wr = prio_reg[dec.prio_idx];
        for (int k = 0; k < LANES; k++)
        begin
            if (lmask[k])
            begin
                prio_wr[k*PRIO_W +: PRIO_W] = write_data[8*k + PRIO_SHIFT +: PRIO_W];
            end
        end
    end

    // Update the bit words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIT_WORDS; i++)
            begin
                enable_reg[i]  <= '0;
                pending_reg[i] <= '0;
                active_reg[i]  <= '0;
            end
        end
        else if (fire)
        begin
            if (dec.wr && dec.hit_set_en)
            begin
                enable_reg[dec.bit_idx] <= enable_reg[dec.bit_idx] | (write_data & wmask);
            end
            if (dec.wr && dec.hit_clr_en)
            begin
                enable_reg[dec.bit_idx] <= enable_reg[dec.bit_idx] & ~write_data;
            end
            if (dec.wr && dec.hit_set_pend)
            begin
                pending_reg[dec.bit_idx] <= pending_reg[dec.bit_idx] | (write_data & wmask);
            end
            if (dec.wr && dec.hit_clr_pend)
            begin
                pending_reg[dec.bit_idx] <= pending_reg[dec.bit_idx] & ~write_data;
            end
            if (dec.act_set && dec.act_ok)
            begin
                active_reg[dec.act_idx][dec.act_bit] <= 1'b1;
            end
            if (dec.act_clr && dec.act_ok)
            begin
                active_reg[dec.act_idx][dec.act_bit] <= 1'b0;
            end
        end
    end

    // Update the priority words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PRIO_WORDS; i++)
            begin
                prio_reg[i] <= '0;
            end
        end
        else if (fire && dec.wr && dec.hit_prio)
        begin
            prio_reg[dec.prio_idx] <= prio_wr;
        end
    end

    // Select the read word; writes and commands return zero
    always_comb
    begin
        read_data = '0;
        if (!dec.wr)
        begin
            priority if (dec.hit_set_en || dec.hit_clr_en)
            begin
                read_data = enable_reg[dec.bit_idx];
            end
            else if (dec.hit_set_pend || dec.hit_clr_pend)
            begin
                read_data = pending_reg[dec.bit_idx];
            end
            else if (dec.hit_active)
            begin
                read_data = active_reg[dec.bit_idx];
            end
            else if (dec.hit_prio)
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    read_data[8*k + PRIO_SHIFT +: PRIO_W] =
                        prio_reg[dec.prio_idx][k*PRIO_W +: PRIO_W];
                end
            end
            else
            begin
                // unmapped word or command: return zero
                read_data = '0;
            end
        end
    end

endmodule

FILE: test/nested_interrupt_controller_regs_tb.sv
// Self-checking testbench for the interrupt controller register block stream interface.
`timescale 1ns / 100ps

module nested_interrupt_controller_regs_tb;
    import nvic_pkg::*;

    // One bus access or active-bit command as offered to the block
    typedef struct {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [ID_W-1:0]   irq;
        bit                drain_first;   // wait for all results before offering
        bit                hold_rx;       // starts a long receiver hold-off
    } access_t;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              addr_error;
    } reg_result_t;

    localparam int RX_HOLD_CYCLES = 200;
    localparam int TAIL_ITEMS     = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // word_address, write_data, irq_id, pad
    logic [CMD_W-1:0]     s_axis_tuser = '0;   // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // read_data
    logic                 m_axis_tuser;        // addr_error

    // Shadow copy of the controller registers
    logic [DATA_W-1:0] enable_bits  [BIT_WORDS];
    logic [DATA_W-1:0] pending_bits [BIT_WORDS];
    logic [DATA_W-1:0] active_bits  [BIT_WORDS];
    logic [PRIO_W-1:0] prio_levels  [NUM_IRQ];

    access_t     access_q[$];
    reg_result_t expected_results[$];
    access_t     cur_item;

    int  exp_pushed    = 0;
    int  results_seen  = 0;
    int  hold_req_cnt  = 0;
    int  hold_seen_cnt = 0;
    int  tx_gap        = 0;
    int  rx_gap        = 0;
    int  rx_hold       = 0;
    bit  tail_phase    = 1'b0;
    int  fail_cnt      = 0;
    int  n_reads       = 0;
    int  n_writes      = 0;
    int  n_act_cmds    = 0;
    int  n_flagged     = 0;

    nested_interrupt_controller_regs i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        fail_cnt++;
        if (fail_cnt <= 40)
        begin
            $display("MISMATCH at %0t: %s, got 0x%08h, expected 0x%08h", $realtime, what,
                     got, want);
        end
    endtask

    // Bits of one bit word that belong to existing interrupt lines
    function automatic logic [DATA_W-1:0] implemented_lines(input int w);
        logic [DATA_W-1:0] m;
        for (int i = 0; i < DATA_W; i++)
        begin
            m[i] = (w * 32 + i < NUM_IRQ);
        end
        return m;
    endfunction

    // Apply one access to the shadow registers and work out its result
    function automatic void predict_access(input access_t a, output reg_result_t r);
        bit wr;
        int w;
        int p;
        int irq;
        wr = (a.cmd == CMD_WRITE);
        r.read_data  = '0;
        r.addr_error = 1'b0;
        if (a.cmd == CMD_ACT_SET || a.cmd == CMD_ACT_CLR)
        begin
            if (a.irq < NUM_IRQ)
            begin
                active_bits[a.irq / 32][a.irq % 32] = (a.cmd == CMD_ACT_SET);
            end
        end
        else if (a.addr >= BASE_SET_EN && a.addr < BASE_SET_EN + BIT_WORDS)
        begin
            w = a.addr - BASE_SET_EN;
            if (wr) enable_bits[w] |= a.data & implemented_lines(w);
            else r.read_data = enable_bits[w];
        end
        else if (a.addr >= BASE_CLR_EN && a.addr < BASE_CLR_EN + BIT_WORDS)
        begin
            w = a.addr - BASE_CLR_EN;
            if (wr) enable_bits[w] &= ~a.data;
            else r.read_data = enable_bits[w];
        end
        else if (a.addr >= BASE_SET_PEND && a.addr < BASE_SET_PEND + BIT_WORDS)
        begin
            w = a.addr - BASE_SET_PEND;
            if (wr) pending_bits[w] |= a.data & implemented_lines(w);
            else r.read_data = pending_bits[w];
        end
        else if (a.addr >= BASE_CLR_PEND && a.addr < BASE_CLR_PEND + BIT_WORDS)
        begin
            w = a.addr - BASE_CLR_PEND;
            if (wr) pending_bits[w] &= ~a.data;
            else r.read_data = pending_bits[w];
        end
        else if (a.addr >= BASE_ACTIVE && a.addr < BASE_ACTIVE + BIT_WORDS)
        begin
            // active window ignores writes without flagging them
            w = a.addr - BASE_ACTIVE;
            if (!wr) r.read_data = active_bits[w];
        end
        else if (a.addr >= BASE_PRIO && a.addr < BASE_PRIO + PRIO_WORDS)
        begin
            p = a.addr - BASE_PRIO;
            for (int k = 0; k < LANES; k++)
            begin
                irq = p * LANES + k;
                if (irq < NUM_IRQ)
                begin
                    if (wr) prio_levels[irq] = a.data[8 * k + PRIO_SHIFT +: PRIO_W];
                    else r.read_data[8 * k + PRIO_SHIFT +: PRIO_W] = prio_levels[irq];
                end
            end
        end
        else
        begin
            r.addr_error = 1'b1;
        end
        if (wr) r.read_data = '0;
    endfunction

    task automatic add_access(input cmd_t cmd, input int addr, input logic [DATA_W-1:0] data,
                              input int irq, input bit drain_first = 1'b0,
                              input bit hold_rx = 1'b0);
        access_t a;
        a.cmd         = cmd;
        a.addr        = addr[ADDR_W-1:0];
        a.data        = data;
        a.irq         = irq[ID_W-1:0];
        a.drain_first = drain_first;
        a.hold_rx     = hold_rx;
        access_q.push_back(a);
    endtask

    // Mostly mapped words, with a slice just past each window and fully random words
    function automatic int pick_address();
        int region;
        region = $urandom_range(0, 9);
        case (region)
            0: return BASE_SET_EN + $urandom_range(0, BIT_WORDS);
            1: return BASE_CLR_EN + $urandom_range(0, BIT_WORDS);
            2: return BASE_SET_PEND + $urandom_range(0, BIT_WORDS);
            3: return BASE_CLR_PEND + $urandom_range(0, BIT_WORDS);
            4: return BASE_ACTIVE + $urandom_range(0, BIT_WORDS);
            5, 6: return BASE_PRIO + $urandom_range(0, PRIO_WORDS);
            default: return $urandom_range(0, (1 << ADDR_W) - 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return 32'd1 << $urandom_range(0, DATA_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // Driver: offer queued items, hold each until it is accepted
    always @(posedge clk)
    begin
        access_t     nxt;
        reg_result_t res;
        int          pushed_now;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            pushed_now = exp_pushed;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_access(cur_item, res);
                expected_results.push_back(res);
                pushed_now++;
                if (cur_item.hold_rx) hold_req_cnt <= hold_req_cnt + 1;
                case (cur_item.cmd)
                    CMD_READ:  n_reads++;
                    CMD_WRITE: n_writes++;
                    default:   n_act_cmds++;
                endcase
            end
            exp_pushed <= pushed_now;
            tail_phase <= (access_q.size() < TAIL_ITEMS);

            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the current item
            end
            else if (tx_gap != 0)
            begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (access_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (access_q[0].drain_first && pushed_now != results_seen)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (!tail_phase && pushed_now[6] && $urandom_range(0, 7) == 0)
            begin
                tx_gap <= $urandom_range(0, 16);
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                nxt = access_q.pop_front();
                cur_item      <= nxt;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, nxt.irq, nxt.data, nxt.addr};
                s_axis_tuser  <= nxt.cmd;
            end
        end
    end

    // Monitor: check each result against the oldest expectation, pace tready
    always @(posedge clk)
    begin
        reg_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (m_axis_tuser) n_flagged++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", m_axis_tdata, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata !== want.read_data)
                        report_mismatch("read_data", m_axis_tdata, want.read_data);
                    if (m_axis_tuser !== want.addr_error)
                        report_mismatch("addr_error", DATA_W'(m_axis_tuser),
                                        DATA_W'(want.addr_error));
                end
            end

            if (rx_hold != 0)
            begin
                rx_hold <= rx_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req_cnt != hold_seen_cnt)
            begin
                hold_seen_cnt <= hold_seen_cnt + 1;
                rx_hold <= RX_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!tail_phase && !results_seen[6] && $urandom_range(0, 5) == 0)
            begin
                rx_gap <= $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int r;
        cmd_t c;
        for (int i = 0; i < BIT_WORDS; i++)
        begin
            enable_bits[i]  = '0;
            pending_bits[i] = '0;
            active_bits[i]  = '0;
        end
        for (int i = 0; i < NUM_IRQ; i++)
        begin
            prio_levels[i] = '0;
        end

        // Directed: window extremes, clear windows reading back, ignored bits
        add_access(CMD_READ,  BASE_SET_EN, 32'hFFFF_FFFF, 63);
        add_access(CMD_WRITE, BASE_SET_EN, 32'hFFFF_FFFF, 0);
        add_access(CMD_WRITE, BASE_SET_EN + 1, 32'hFFFF_FFFF, 0);
        add_access(CMD_READ,  BASE_CLR_EN + 1, 32'h0, 0);
        add_access(CMD_WRITE, BASE_CLR_EN, 32'h0000_FFFF, 0);
        add_access(CMD_READ,  BASE_SET_EN, 32'h0, 0);
        add_access(CMD_WRITE, BASE_SET_PEND, 32'hFFFF_FFFF, 0);
        add_access(CMD_WRITE, BASE_CLR_PEND, 32'h8000_0001, 0);
        add_access(CMD_READ,  BASE_CLR_PEND, 32'h0, 0);
        add_access(CMD_ACT_SET, BASE_ACTIVE, 32'h0, 0);
        add_access(CMD_ACT_SET, 0, 32'h0, 63);
        add_access(CMD_READ,  BASE_ACTIVE, 32'h0, 0);
        add_access(CMD_WRITE, BASE_ACTIVE + 1, 32'h0, 0);
        add_access(CMD_READ,  BASE_ACTIVE + 1, 32'h0, 0);
        add_access(CMD_ACT_CLR, 0, 32'hFFFF_FFFF, 63);
        add_access(CMD_READ,  BASE_ACTIVE + 1, 32'h0, 0);
        add_access(CMD_WRITE, BASE_PRIO, 32'hFFFF_FFFF, 0);
        add_access(CMD_READ,  BASE_PRIO, 32'h0, 0);
        add_access(CMD_WRITE, BASE_PRIO + PRIO_WORDS - 1, 32'hA5A5_A5A5, 0);
        add_access(CMD_READ,  BASE_PRIO + PRIO_WORDS - 1, 32'h0, 0);
        // Directed: unmapped words, inside and outside the windows
        add_access(CMD_READ,  0, 32'h0, 0);
        add_access(CMD_WRITE, (1 << ADDR_W) - 1, 32'hFFFF_FFFF, 0);
        add_access(CMD_READ,  BASE_SET_EN + BIT_WORDS, 32'h0, 0);
        add_access(CMD_READ,  BASE_PRIO + PRIO_WORDS, 32'h0, 0);

        // Random accesses; a few items trigger a drain or a long receiver hold-off
        for (int i = 0; i < 1150; i++)
        begin
            r = $urandom_range(0, 19);
            if (r < 7) c = CMD_READ;
            else if (r < 14) c = CMD_WRITE;
            else if (r < 17) c = CMD_ACT_SET;
            else c = CMD_ACT_CLR;
            add_access(c, pick_address(), pick_data(), $urandom_range(0, (1 << ID_W) - 1),
                       (i == 300 || i == 700), (i == 400 || i == 850));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (access_q.size() != 0 || s_axis_tvalid) @(posedge clk);
        while (results_seen != exp_pushed) @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("expected results left over", expected_results.size(), '0);

        $display("Covered %0d bus reads, %0d bus writes, %0d active-bit commands, %0d flagged",
                 n_reads, n_writes, n_act_cmds, n_flagged);
        $display("unmapped accesses, with idle bursts, two drains and two long result stalls.");
        if (fail_cnt == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
